// File: src/mru_pkg.sv
`timescale 1ns / 1ps
// Shared types for the recent-entries MRU list.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mru_pkg;

	// One stored preset: mode, value, clock minute, day offset (53 bits)
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
		logic [10:0] minute;
		logic [7:0]  day;
	} mru_entry_t;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_LIST = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  entry_mode_in;
		logic [31:0] offset_value;
		logic [31:0] target_value;
		logic [10:0] clock_minute_in;
		logic [7:0]  day_shift_in;
	} mru_req_t;

	typedef struct packed {
		logic        valid_res;
		logic [5:0]  slot;
		logic [1:0]  entry_mode;
		logic [31:0] entry_value;
		logic [10:0] entry_clock_minute;
		logic [7:0]  entry_day_shift;
		logic [6:0]  list_count;
		logic        last;
	} mru_rsp_t;

	typedef struct packed {
		logic [1:0] data;
	} mru_cfg_t;

	// Controller -> datapath
	typedef struct packed {
		logic capture;
		logic rd;
		logic merge;
		logic flush;
		logic emit;
		logic emit_empty;
	} mru_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_add;
		logic rd_more;
		logic cnt_zero;
		logic out_free;
	} mru_stat_t;

endpackage

// File: src/mru_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on mru_pkg for the payload types.
interface mru_req_if;
	import mru_pkg::*;
	logic     valid;
	logic     ready;
	mru_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mru_rsp_if;
	import mru_pkg::*;
	logic     valid;
	logic     ready;
	mru_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mru_cfg_if;
	import mru_pkg::*;
	logic     valid;
	logic     ready;
	mru_cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/mru_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the MRU list: merge pass on add, then emit pass.
// Depends on mru_pkg for command and status types.
module mru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mru_pkg::mru_stat_t st,
	output mru_pkg::mru_cmd_t  cmd
);
	import mru_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DISP  = 7'b0000010,
		S_A_RD  = 7'b0000100,
		S_A_CMP = 7'b0001000,
		S_A_FL  = 7'b0010000,
		S_L_RD  = 7'b0100000,
		S_L_OUT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   empty_q, empty_d;   // list pass on empty list pending

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			empty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			empty_q <= empty_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		empty_d  = empty_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				if (st.is_add) begin
					state_d = st.rd_more ? S_A_RD : S_A_FL;
				end else begin
					empty_d = st.cnt_zero;
					state_d = st.cnt_zero ? S_L_OUT : S_L_RD;
				end
			end
			S_A_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_A_CMP;
			end
			S_A_CMP: begin
				cmd.merge = 1'b1;
				state_d   = st.rd_more ? S_A_RD : S_A_FL;
			end
			S_A_FL: begin
				cmd.flush = 1'b1;
				state_d   = S_L_RD;
			end
			S_L_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_L_OUT;
			end
			S_L_OUT: begin
				if (st.out_free) begin
					if (empty_q) begin
						cmd.emit_empty = 1'b1;
						empty_d        = 1'b0;
						state_d        = S_IDLE;
					end else begin
						cmd.emit = 1'b1;
						state_d  = st.rd_more ? S_L_RD : S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: src/mru_dp.sv
`timescale 1ns / 1ps
// Datapath for the MRU list: entry memory, merge carry, counters, output register.
// Depends on mru_pkg for entry, payload, command and status types.
module mru_dp #(
	parameter int LIST_CAPACITY = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mru_pkg::mru_req_t  req,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	input  mru_pkg::mru_cmd_t  cmd,
	output mru_pkg::mru_stat_t st,
	output logic               out_valid,
	input  logic               out_ready,
	output mru_pkg::mru_rsp_t  out_data
);
	import mru_pkg::*;

	localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
	localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(LIST_CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	mru_entry_t       mem [LIST_CAPACITY];
	mru_entry_t       fresh_q, carry_q, rd_data_q;
	mru_rsp_t         out_q;
	logic             out_vld_q;
	logic [1:0]       upm_q;
	logic             is_add_q;
	logic [CNT_W-1:0] cnt_q, rd_idx_q, wr_idx_q;
	logic             keep, wr_room, we, out_free;
	mru_entry_t       fresh_d;

	assign keep     = (rd_data_q != fresh_q);
	assign wr_room  = (wr_idx_q < CAP_C);
	assign we       = (cmd.merge && keep) || (cmd.flush && wr_room);
	assign out_free = !out_vld_q || out_ready;

	always_comb begin
		fresh_d.mode   = req.entry_mode_in;
		fresh_d.value  = (req.entry_mode_in == upm_q) ? req.offset_value : req.target_value;
		fresh_d.minute = req.clock_minute_in;
		fresh_d.day    = req.day_shift_in;
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[wr_idx_q[IDX_W-1:0]] <= carry_q;
		if (cmd.rd) rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fresh_q <= fresh_d;
			carry_q <= fresh_d;
		end else if (cmd.merge && keep) begin
			carry_q <= rd_data_q;
		end
		if (cmd.emit) begin
			out_q.valid_res          <= 1'b1;
			out_q.slot               <= 6'(CNT_W'(rd_idx_q - ONE_C));
			out_q.entry_mode         <= rd_data_q.mode;
			out_q.entry_value        <= rd_data_q.value;
			out_q.entry_clock_minute <= rd_data_q.minute;
			out_q.entry_day_shift    <= rd_data_q.day;
			out_q.list_count         <= 7'(cnt_q);
			out_q.last               <= (rd_idx_q == cnt_q);
		end else if (cmd.emit_empty) begin
			out_q.valid_res          <= 1'b0;
			out_q.slot               <= 6'd0;
			out_q.entry_mode         <= 2'd0;
			out_q.entry_value        <= 32'd0;
			out_q.entry_clock_minute <= 11'd0;
			out_q.entry_day_shift    <= 8'd0;
			out_q.list_count         <= 7'd0;
			out_q.last               <= 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upm_q     <= 2'd0;
			is_add_q  <= 1'b0;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) upm_q <= cfg_data;
			if (cmd.capture) begin
				is_add_q <= (req.opcode == OP_ADD);
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end else if (cmd.rd) begin
				rd_idx_q <= CNT_W'(rd_idx_q + ONE_C);
			end else if (cmd.flush) begin
				rd_idx_q <= '0;
			end
			if (cmd.merge && keep) wr_idx_q <= CNT_W'(wr_idx_q + ONE_C);
			if (cmd.flush) cnt_q <= wr_room ? CNT_W'(wr_idx_q + ONE_C) : wr_idx_q;
			if (cmd.emit || cmd.emit_empty) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	assign st.is_add   = is_add_q;
	assign st.rd_more  = (rd_idx_q < cnt_q);
	assign st.cnt_zero = (cnt_q == '0);
	assign st.out_free = out_free;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// File: src/recent_entries_mru_list_top.sv
`timescale 1ns / 1ps
// Top level of the recent-entries MRU list: controller, datapath, config register.
// Depends on mru_pkg, mru_ifs, mru_ctrl and mru_dp.
//
// Usage:
//   req  - one transaction per add (opcode 0) or list (opcode 1) request.
//   rsp  - one transaction per list entry, front (slot 0) to back, last set on
//          the final one; an empty list gives a single transaction with
//          valid_res 0, last 1 and all other fields 0.
//   cfg  - writes up_mode_code; always ready, to be written while idle.
// Flow: requests are handled one at a time; req.ready is high only while
//   the sequencer is idle. An add first runs a merge pass in which every
//   entry held before the add costs a memory read plus a compare/write
//   step on the entry store, then a flush step. The list pass then reads
//   each entry and loads the output register, waiting while it is full.
// Stalls: results sit in the output register until rsp.ready; the emit pass
//   waits on a full output register, nothing is dropped.
// Reset: arst_n clears the list count, sequencer and up_mode_code to 0; the
//   entry memory is not cleared, as only entries below the count are read.
module recent_entries_mru_list_top #(
	parameter int LIST_CAPACITY = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	mru_req_if.sink    req,
	mru_rsp_if.source  rsp,
	mru_cfg_if.sink    cfg
);
	import mru_pkg::*;

	mru_cmd_t  cmd;
	mru_stat_t st;
	logic      cfg_we;

	// Configuration register never back-pressures
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	mru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	mru_dp #(
		.LIST_CAPACITY (LIST_CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg.data.data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp.data)
	);

	// Count reported never exceeds the configured capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.list_count <= 7'(LIST_CAPACITY)))
		else $error("list_count above capacity");

	// The final entry result sits in the last slot
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.valid_res && rsp.data.last) |->
		(7'(rsp.data.slot) == 7'(rsp.data.list_count - 7'd1)))
		else $error("last marker not on final slot");

	// An empty-list result is alone and carries a zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.valid_res) |->
		(rsp.data.last && (rsp.data.list_count == 7'd0)))
		else $error("malformed empty-list result");

	// No new request is taken while a list pass is still being emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.last) |-> !req.ready)
		else $error("request accepted mid list");

endmodule
